@@ hdl/dbd_pkg.sv @@
package dbd_pkg;

   localparam int DateW = 32;
   localparam int DayW  = 22;
   localparam int AccW  = DayW + 1;
   localparam int MulAW = 16;
   localparam int MulBW = 9;
   localparam int StepW = 3;

   localparam logic [StepW-1:0] STEP_CENT  = 3'd0;
   localparam logic [StepW-1:0] STEP_YEAR  = 3'd1;
   localparam logic [StepW-1:0] STEP_CQUAD = 3'd2;
   localparam logic [StepW-1:0] STEP_YQUAD = 3'd3;
   localparam logic [StepW-1:0] STEP_ADJ   = 3'd4;
   localparam logic [StepW-1:0] STEP_MONTH = 3'd5;
   localparam logic [StepW-1:0] STEP_DAY   = 3'd6;

   localparam logic [MulAW-1:0] DaysPerCent = 16'd36524;
   localparam logic [MulAW-1:0] DaysPerYear = 16'd365;
   localparam logic [MulAW-1:0] UnitFactor  = 16'd1;

   typedef struct packed {
      logic             ok;
      logic             leap;
      logic [6:0]       cent;
      logic [6:0]       yy;
      logic [8:0]       days_before;
      logic [7:0]       day_term;
   } fields_type;

   typedef struct packed {
      logic en;
      logic clear;
      logic sub_wide;
   } mac_op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_SUB  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

@@ hdl/dbd_fields.sv @@
module dbd_fields (
   input  logic [dbd_pkg::DateW-1:0] date_bcd,
   output dbd_pkg::fields_type       fld
);
   import dbd_pkg::*;

   logic       digits_ok;
   logic [7:0] day_bin;
   logic [7:0] mon_bin;
   logic [7:0] cent_bin;
   logic [7:0] yy_bin;
   logic       leap;
   logic       mon_ok;
   logic       day_ok;
   logic [4:0] mlen;
   logic       extra;

   always_comb begin
      digits_ok = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (date_bcd[4*k +: 4] > 4'd9) begin
            digits_ok = 1'b0;
         end
      end
   end

   assign day_bin  = 8'(date_bcd[31:28]) * 8'd10 + 8'(date_bcd[27:24]);
   assign mon_bin  = 8'(date_bcd[23:20]) * 8'd10 + 8'(date_bcd[19:16]);
   assign cent_bin = 8'(date_bcd[15:12]) * 8'd10 + 8'(date_bcd[11:8]);
   assign yy_bin   = 8'(date_bcd[7:4]) * 8'd10 + 8'(date_bcd[3:0]);

   // divisible by 4; a century year only when the century count is divisible by 4 too
   assign leap = (yy_bin[1:0] == 2'd0) && ((yy_bin != 8'd0) || (cent_bin[1:0] == 2'd0));

   assign mon_ok = (mon_bin >= 8'd1) && (mon_bin <= 8'd12);
   assign mlen   = month_len(mon_bin[3:0], leap);
   assign day_ok = (day_bin >= 8'd1) && (day_bin <= 8'(mlen));
   assign extra  = leap && (mon_bin[3:0] > 4'd2);

   assign fld.ok          = digits_ok && mon_ok && day_ok;
   assign fld.leap        = leap;
   assign fld.cent        = cent_bin[6:0];
   assign fld.yy          = yy_bin[6:0];
   assign fld.days_before = days_before_month(mon_bin[3:0]);
   assign fld.day_term    = day_bin - 8'd1 + 8'(extra);

endmodule

@@ hdl/dbd_mac.sv @@
module dbd_mac (
   input  logic                      clock,
   input  dbd_pkg::mac_op_type       op,
   input  logic [dbd_pkg::MulAW-1:0] mul_a,
   input  logic [dbd_pkg::MulBW-1:0] mul_b,
   input  logic [dbd_pkg::DayW-1:0]  wide,
   output logic [dbd_pkg::AccW-1:0]  acc
);
   import dbd_pkg::*;

   logic [MulAW+MulBW-1:0] prod;
   logic [AccW-1:0]        addend;
   logic [AccW-1:0]        base;
   logic [AccW-1:0]        acc_ff;
   logic [AccW-1:0]        acc_in;

   assign prod   = (MulAW+MulBW)'(mul_a) * (MulAW+MulBW)'(mul_b);
   assign addend = op.sub_wide ? (~AccW'(wide) + AccW'(1)) : prod[AccW-1:0];
   assign base   = op.clear ? '0 : acc_ff;
   assign acc_in = base + addend;

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ hdl/days_between_dates.sv @@
// Day count between two BCD dates (DD MM YYYY, day tens in the top nibble), Gregorian
// calendar. Each date is turned into a day number since 01/01/0000 by one shared
// multiply-add unit that adds seven terms, one per cycle, then the same unit subtracts
// the start from the end. From acceptance to the result showing on rsp_tvalid, the unit
// runs the terms of both dates, the subtract and the output register load, with
// req_tready low throughout, so a new request is taken only after the last result is
// loaded. A bad digit, month or day, or an end date before the start date, gives
// rsp_tuser high and a count of zero. The result sits in an output register; the next
// request is taken while it waits, and if that register is still full when the next
// result is ready, the unit holds it and keeps req_tready low until rsp_tready frees it.
module days_between_dates (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // start_date_bcd[31:0], end_date_bcd[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // day_count[21:0], zero pad[23:22]
   output logic        rsp_tuser    // date_error[0]
);
   import dbd_pkg::*;

   state_type         state_ff, state_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic              sel_ff, sel_in;
   logic              err_ff, err_in;
   logic [DateW-1:0]  start_bcd_ff, start_bcd_in;
   logic [DateW-1:0]  end_bcd_ff, end_bcd_in;
   logic [DayW-1:0]   start_dn_ff, start_dn_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DayW-1:0]   rsp_count_ff, rsp_count_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [DateW-1:0]  cur_bcd;
   fields_type        fld;
   mac_op_type        op;
   logic [MulAW-1:0]  mul_a;
   logic [MulBW-1:0]  mul_b;
   logic [AccW-1:0]   acc;
   logic [7:0]        yy_quad;
   logic              out_free;
   logic              bad;

   assign cur_bcd = sel_ff ? end_bcd_ff : start_bcd_ff;

   dbd_fields u_fields (
      .date_bcd (cur_bcd),
      .fld      (fld)
   );

   dbd_mac u_mac (
      .clock (clock),
      .op    (op),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .wide  (start_dn_ff),
      .acc   (acc)
   );

   assign yy_quad = (8'(fld.yy) + 8'd3) >> 2;

   always_comb begin
      mul_a = UnitFactor;
      mul_b = '0;
      case (step_ff)
         STEP_CENT: begin
            mul_a = DaysPerCent;
            mul_b = MulBW'(fld.cent);
         end
         STEP_YEAR: begin
            mul_a = DaysPerYear;
            mul_b = MulBW'(fld.yy);
         end
         STEP_CQUAD: mul_b = MulBW'(fld.cent[6:2]);
         STEP_YQUAD: mul_b = MulBW'(yy_quad);
         STEP_ADJ:   mul_b = MulBW'((fld.yy == 7'd0) && (fld.cent[1:0] != 2'd0));
         STEP_MONTH: mul_b = fld.days_before;
         STEP_DAY:   mul_b = MulBW'(fld.day_term);
         default:    mul_b = '0;
      endcase
   end

   always_comb begin
      op.en       = (state_ff == ST_CALC) || (state_ff == ST_SUB);
      op.clear    = (state_ff == ST_CALC) && (step_ff == STEP_CENT);
      op.sub_wide = (state_ff == ST_SUB);
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign bad      = err_ff || acc[AccW-1];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      start_bcd_in = start_bcd_ff;
      end_bcd_in   = end_bcd_ff;
      start_dn_in  = start_dn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               start_bcd_in = req_tdata[31:0];
               end_bcd_in   = req_tdata[63:32];
               step_in      = STEP_CENT;
               sel_in       = 1'b0;
               err_in       = 1'b0;
               state_in     = ST_CALC;
            end
         end
         ST_CALC: begin
            err_in = err_ff || !fld.ok;
            // hold the start day number before the end date overwrites the unit
            if (sel_ff && (step_ff == STEP_CENT)) begin
               start_dn_in = acc[DayW-1:0];
            end
            if (step_ff == STEP_DAY) begin
               step_in = STEP_CENT;
               sel_in  = 1'b1;
               if (sel_ff) begin
                  state_in = ST_SUB;
               end
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         ST_SUB: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = bad;
               rsp_count_in = bad ? '0 : acc[DayW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      sel_ff       <= sel_in;
      err_ff       <= err_in;
      start_bcd_ff <= start_bcd_in;
      end_bcd_ff   <= end_bcd_in;
      start_dn_ff  <= start_dn_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

@@ hdl/dbd_checker.sv @@
module dbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("error result with nonzero count");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (.*);

@@ sim/tb.sv @@
module tb;
   import dbd_pkg::*;

   typedef struct packed {
      logic [DayW-1:0] day_count;
      logic            date_error;
   } span_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // start_date_bcd[31:0], end_date_bcd[63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // day_count[21:0], zero pad[23:22]
   logic        rsp_tuser;         // date_error[0]

   logic [63:0] date_pairs [$];
   span_type    owed_spans [$];
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          accepted = 0;
   int          mismatches = 0;
   int          checked = 0;
   int          flagged = 0;
   int unsigned longest = 0;

   days_between_dates i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic bit leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_days(input int unsigned mon, input bit leap);
      case (mon)
         4, 6, 9, 11: return 30;
         2:           return leap ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic bit to_day_number(input logic [31:0] bcd, output int unsigned dn);
      int unsigned k, m, day, mon, yr;
      bit leap;
      dn = 0;
      for (k = 0; k < 8; k++) begin
         if (bcd[31-4*k -: 4] > 4'd9) return 1'b0;
      end
      day = bcd[31:28] * 10 + bcd[27:24];
      mon = bcd[23:20] * 10 + bcd[19:16];
      yr  = bcd[15:12] * 1000 + bcd[11:8] * 100 + bcd[7:4] * 10 + bcd[3:0];
      leap = leap_year(yr);
      if (mon < 1 || mon > 12) return 1'b0;
      if (day < 1 || day > month_days(mon, leap)) return 1'b0;
      dn = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + day - 1;
      for (m = 1; m < mon; m++) dn += month_days(m, leap);
      return 1'b1;
   endfunction

   function automatic span_type date_span(input logic [63:0] pair);
      span_type s;
      int unsigned start_dn, end_dn;
      bit start_ok, end_ok;
      start_ok = to_day_number(pair[31:0], start_dn);
      end_ok   = to_day_number(pair[63:32], end_dn);
      if (!start_ok || !end_ok || end_dn < start_dn) begin
         s.day_count  = '0;
         s.date_error = 1'b1;
      end else begin
         s.day_count  = DayW'(end_dn - start_dn);
         s.date_error = 1'b0;
      end
      return s;
   endfunction

   function automatic logic [31:0] bcd_date(input int unsigned d, m, y);
      return {4'(d / 10), 4'(d % 10), 4'(m / 10), 4'(m % 10),
              4'(y / 1000), 4'(y / 100 % 10), 4'(y / 10 % 10), 4'(y % 10)};
   endfunction

   function automatic int unsigned rand_year();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 99) * 100;
         1:       return $urandom_range(0, 2499) * 4;
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   function automatic logic [31:0] rand_date(input int unsigned y);
      int unsigned m, d;
      m = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) begin
         m = 2;
         d = $urandom_range(28, month_days(2, leap_year(y)));
      end else begin
         d = $urandom_range(1, month_days(m, leap_year(y)));
      end
      return bcd_date(d, m, y);
   endfunction

   function automatic logic [63:0] ordered(input logic [31:0] a, b);
      int unsigned da, db;
      bit ok;
      ok = to_day_number(a, da);
      ok = to_day_number(b, db);
      return (db < da) ? {a, b} : {b, a};
   endfunction

   function automatic logic [31:0] spoil(input logic [31:0] w);
      int unsigned k, y;
      y = rand_year();
      case ($urandom_range(0, 5))
         0: begin
            k = $urandom_range(0, 7);
            w[4*k +: 4] = 4'($urandom_range(10, 15));
         end
         1: w[23:16] = ($urandom_range(0, 1) == 0) ? 8'h00 : {4'h1, 4'($urandom_range(3, 9))};
         2: w[31:24] = ($urandom_range(0, 1) == 0) ? 8'h00 : {4'h3, 4'($urandom_range(2, 9))};
         3: w = bcd_date(31, 4 + 2 * $urandom_range(0, 1) + 5 * $urandom_range(0, 1), y);
         4: w = bcd_date(30, 2, y);
         default: w = bcd_date(29, 2, 4 * $urandom_range(0, 2499) + $urandom_range(1, 3));
      endcase
      return w;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t with %0d responses outstanding", $time, owed_spans.size());
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed_spans.push_back(date_span(req_tdata));
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (date_pairs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (date_pairs.size() > 150 && $urandom_range(0, 5) == 0) begin
               send_gap   <= $urandom_range(0, 13);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= date_pairs.pop_front();
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // hold off the response side once, long enough to back up the request side
   always @(posedge clock) begin
      if (!hold_done && accepted == 300) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap   <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else if (date_pairs.size() > 150 && $urandom_range(0, 5) == 0) begin
         recv_gap   <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      span_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_spans.size() == 0) begin
            $display("%0t: response with no request outstanding, day_count %0d date_error %0b",
                     $time, rsp_tdata[DayW-1:0], rsp_tuser);
            mismatches++;
         end else begin
            want = owed_spans.pop_front();
            checked++;
            if (want.date_error) flagged++;
            if (want.day_count > longest) longest = want.day_count;
            if (rsp_tdata[DayW-1:0] !== want.day_count) begin
               $display("%0t: day_count expected %0d, got %0d",
                        $time, want.day_count, rsp_tdata[DayW-1:0]);
               mismatches++;
            end
            if (rsp_tuser !== want.date_error) begin
               $display("%0t: date_error expected %0b, got %0b",
                        $time, want.date_error, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [31:0] a, b;
      int unsigned y;
      int n;

      date_pairs.push_back({bcd_date(15, 6, 2023), bcd_date(15, 6, 2023)});
      date_pairs.push_back({bcd_date(1, 1, 0), bcd_date(1, 1, 0)});
      date_pairs.push_back({bcd_date(31, 12, 9999), bcd_date(1, 1, 0)});
      date_pairs.push_back({bcd_date(1, 1, 0), bcd_date(31, 12, 9999)});
      date_pairs.push_back({bcd_date(1, 3, 2000), bcd_date(28, 2, 2000)});
      date_pairs.push_back({bcd_date(1, 3, 1900), bcd_date(28, 2, 1900)});
      date_pairs.push_back({bcd_date(1, 3, 0), bcd_date(29, 2, 0)});
      date_pairs.push_back({bcd_date(1, 3, 1900), bcd_date(29, 2, 1900)});
      date_pairs.push_back({bcd_date(29, 2, 2028), bcd_date(29, 2, 2024)});
      date_pairs.push_back({bcd_date(1, 1, 2000), bcd_date(31, 12, 1999)});
      date_pairs.push_back({bcd_date(29, 2, 2100), bcd_date(1, 1, 2100)});
      date_pairs.push_back({bcd_date(29, 2, 2400), bcd_date(1, 1, 2400)});
      date_pairs.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      date_pairs.push_back({32'h0000_0000, 32'h0000_0000});
      date_pairs.push_back({bcd_date(1, 1, 2020), bcd_date(1, 13, 2019)});
      date_pairs.push_back({bcd_date(0, 5, 2020), bcd_date(1, 1, 2020)});
      date_pairs.push_back({bcd_date(1, 2, 2020), bcd_date(32, 1, 2020)});
      date_pairs.push_back({bcd_date(1, 5, 2021), bcd_date(31, 4, 2021)});
      date_pairs.push_back({bcd_date(1, 1, 2020), bcd_date(2, 1, 2020)});
      date_pairs.push_back({bcd_date(1, 1, 2021), 32'h0101_201A});
      date_pairs.push_back({32'hF101_2021, bcd_date(1, 1, 2021)});
      date_pairs.push_back({bcd_date(31, 12, 9999), bcd_date(31, 12, 9998)});

      for (n = 0; n < 1380; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
               date_pairs.push_back(ordered(rand_date(rand_year()), rand_date(rand_year())));
            end
            10, 11, 12, 13: begin
               y = rand_year();
               a = rand_date(y);
               b = rand_date((y < 9999 && $urandom_range(0, 2) == 0) ? y + 1 : y);
               date_pairs.push_back(ordered(a, b));
            end
            14, 15: begin
               date_pairs.push_back({rand_date(rand_year()), rand_date(rand_year())});
            end
            16, 17: begin
               a = rand_date(rand_year());
               b = rand_date(rand_year());
               if ($urandom_range(0, 1) == 0) a = spoil(a);
               else b = spoil(b);
               date_pairs.push_back({b, a});
            end
            default: begin
               date_pairs.push_back({32'($urandom), 32'($urandom)});
            end
         endcase
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (date_pairs.size() != 0 || req_tvalid || owed_spans.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);

      $display("%0d date pairs checked, %0d flagged as invalid or reversed", checked, flagged);
      $display("longest span seen: %0d days, one long response back-pressure stretch", longest);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
